// ===== rtl/rlcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rlcp_pkg
// Shared widths, constants and payload types for the ray/line closest
// parameter pipeline.
// ----------------------------------------------------------------------------
package rlcp_pkg;

    // Coordinate, difference and dot-product widths
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = COORD_W + DIFF_W;
    localparam int DOT_W   = PROD_W + 1;

    // Wide product and determinant widths
    localparam int MUL_W   = 2 * DOT_W;
    localparam int NUM_W   = MUL_W + 1;
    localparam int MUL_LAT = 4;

    // Result and threshold widths
    localparam int PARAM_W = 32;
    localparam int EPS_W   = 32;
    localparam logic [EPS_W-1:0] EPS_RESET = 32'd281475;
    localparam int PARAM_FRAC_DEFAULT = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] ray_origin_x;
        logic signed [COORD_W-1:0] ray_origin_y;
        logic signed [COORD_W-1:0] ray_origin_z;
        logic signed [COORD_W-1:0] ray_dir_x;
        logic signed [COORD_W-1:0] ray_dir_y;
        logic signed [COORD_W-1:0] ray_dir_z;
        logic signed [COORD_W-1:0] line_origin_x;
        logic signed [COORD_W-1:0] line_origin_y;
        logic signed [COORD_W-1:0] line_origin_z;
        logic signed [COORD_W-1:0] line_dir_x;
        logic signed [COORD_W-1:0] line_dir_y;
        logic signed [COORD_W-1:0] line_dir_z;
    } ray_line_in_t;

    typedef struct packed {
        logic signed [PARAM_W-1:0] line_param;
        logic                      param_valid;
    } ray_line_out_t;

    typedef struct packed {
        logic signed [DOT_W-1:0] uu;
        logic signed [DOT_W-1:0] vv;
        logic signed [DOT_W-1:0] uv;
        logic signed [DOT_W-1:0] uw;
        logic signed [DOT_W-1:0] vw;
    } dots_t;

endpackage

// ===== rtl/rlcp_dot.sv =====
// ----------------------------------------------------------------------------
// rlcp_dot
// Three-stage front end: capture the transaction and form w = Q - P, take
// the fifteen coordinate products, then sum them into the five dot products.
// ----------------------------------------------------------------------------
module rlcp_dot (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  rlcp_pkg::ray_line_in_t    in_data,
    output logic                      out_valid,
    output rlcp_pkg::dots_t           out_dots
);
    import rlcp_pkg::*;

    logic signed [COORD_W-1:0] u_next [3];
    logic signed [COORD_W-1:0] v_next [3];
    logic signed [DIFF_W-1:0]  w_next [3];
    logic signed [COORD_W-1:0] u_reg [3];
    logic signed [COORD_W-1:0] v_reg [3];
    logic signed [DIFF_W-1:0]  w_reg [3];
    logic signed [PROD_W-1:0]  uu_reg [3];
    logic signed [PROD_W-1:0]  vv_reg [3];
    logic signed [PROD_W-1:0]  uv_reg [3];
    logic signed [PROD_W-1:0]  uw_reg [3];
    logic signed [PROD_W-1:0]  vw_reg [3];
    dots_t                     dots_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;

    // Unpack the vectors and form the origin difference
    always_comb
    begin
        u_next[0] = in_data.ray_dir_x;
        u_next[1] = in_data.ray_dir_y;
        u_next[2] = in_data.ray_dir_z;
        v_next[0] = in_data.line_dir_x;
        v_next[1] = in_data.line_dir_y;
        v_next[2] = in_data.line_dir_z;
        w_next[0] = DIFF_W'(in_data.line_origin_x) - DIFF_W'(in_data.ray_origin_x);
        w_next[1] = DIFF_W'(in_data.line_origin_y) - DIFF_W'(in_data.ray_origin_y);
        w_next[2] = DIFF_W'(in_data.line_origin_z) - DIFF_W'(in_data.ray_origin_z);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Capture, multiply, sum
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_reg[i]  <= u_next[i];
            v_reg[i]  <= v_next[i];
            w_reg[i]  <= w_next[i];
            uu_reg[i] <= PROD_W'(u_reg[i]) * PROD_W'(u_reg[i]);
            vv_reg[i] <= PROD_W'(v_reg[i]) * PROD_W'(v_reg[i]);
            uv_reg[i] <= PROD_W'(u_reg[i]) * PROD_W'(v_reg[i]);
            uw_reg[i] <= PROD_W'(u_reg[i]) * PROD_W'(w_reg[i]);
            vw_reg[i] <= PROD_W'(v_reg[i]) * PROD_W'(w_reg[i]);
        end
        dots_reg.uu <= DOT_W'(uu_reg[0]) + DOT_W'(uu_reg[1]) + DOT_W'(uu_reg[2]);
        dots_reg.vv <= DOT_W'(vv_reg[0]) + DOT_W'(vv_reg[1]) + DOT_W'(vv_reg[2]);
        dots_reg.uv <= DOT_W'(uv_reg[0]) + DOT_W'(uv_reg[1]) + DOT_W'(uv_reg[2]);
        dots_reg.uw <= DOT_W'(uw_reg[0]) + DOT_W'(uw_reg[1]) + DOT_W'(uw_reg[2]);
        dots_reg.vw <= DOT_W'(vw_reg[0]) + DOT_W'(vw_reg[1]) + DOT_W'(vw_reg[2]);
    end

    assign out_valid = v3_reg;
    assign out_dots  = dots_reg;

endmodule

// ===== rtl/rlcp_wmul.sv =====
// ----------------------------------------------------------------------------
// rlcp_wmul
// Four-stage signed multiplier for wide operands: magnitude, four half-width
// partial products, partial product sum, sign restore.
// ----------------------------------------------------------------------------
module rlcp_wmul #(
    parameter int W = rlcp_pkg::DOT_W
) (
    input  logic                  clk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);
    localparam int LO = W / 2;
    localparam int HI = W - LO;
    localparam int PW = 2 * W;

    logic [W-1:0]       mag_a_reg;
    logic [W-1:0]       mag_b_reg;
    logic               neg1_reg;
    logic [2*LO-1:0]    ll_reg;
    logic [LO+HI-1:0]   lh_reg;
    logic [LO+HI-1:0]   hl_reg;
    logic [2*HI-1:0]    hh_reg;
    logic               neg2_reg;
    logic [PW-1:0]      sum_reg;
    logic               neg3_reg;
    logic signed [PW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        // Take magnitudes
        mag_a_reg <= a[W-1] ? $unsigned(-a) : $unsigned(a);
        mag_b_reg <= b[W-1] ? $unsigned(-b) : $unsigned(b);
        neg1_reg  <= a[W-1] ^ b[W-1];
        // Partial products
        ll_reg   <= (2*LO)'(mag_a_reg[LO-1:0]) * (2*LO)'(mag_b_reg[LO-1:0]);
        lh_reg   <= (LO+HI)'(mag_a_reg[LO-1:0]) * (LO+HI)'(mag_b_reg[W-1:LO]);
        hl_reg   <= (LO+HI)'(mag_a_reg[W-1:LO]) * (LO+HI)'(mag_b_reg[LO-1:0]);
        hh_reg   <= (2*HI)'(mag_a_reg[W-1:LO]) * (2*HI)'(mag_b_reg[W-1:LO]);
        neg2_reg <= neg1_reg;
        // Combine
        sum_reg  <= (PW'(hh_reg) << (2*LO)) + ((PW'(lh_reg) + PW'(hl_reg)) << LO)
                    + PW'(ll_reg);
        neg3_reg <= neg2_reg;
        // Restore the sign
        p_reg    <= neg3_reg ? -$signed(sum_reg) : $signed(sum_reg);
    end

    assign p = p_reg;

endmodule

// ===== rtl/rlcp_div.sv =====
// ----------------------------------------------------------------------------
// rlcp_div
// Pipelined restoring divider: one quotient bit per stage. The entry stage
// scales the numerator and flags a quotient that needs more than QW bits.
// A sideband word travels with each transaction.
// ----------------------------------------------------------------------------
module rlcp_div #(
    parameter int NW   = rlcp_pkg::NUM_W,
    parameter int DW   = rlcp_pkg::NUM_W,
    parameter int QW   = rlcp_pkg::PARAM_W,
    parameter int FRAC = rlcp_pkg::PARAM_FRAC_DEFAULT,
    parameter int SW   = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] side_out
);
    localparam int RW   = NW + FRAC;
    localparam int SPAN = DW + QW;
    localparam int XW   = ((RW > SPAN) ? RW : SPAN) + 1;

    logic [XW-1:0] rem_reg   [QW+1];
    logic [DW-1:0] den_reg   [QW+1];
    logic [QW-1:0] quo_reg   [QW+1];
    logic          ovf_reg   [QW+1];
    logic [SW-1:0] side_reg  [QW+1];
    logic          valid_reg [QW+1];
    logic [XW-1:0] scaled;

    assign scaled = XW'({num, {FRAC{1'b0}}});

    // Entry stage: scale and check the quotient range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= scaled;
        den_reg[0]  <= den;
        quo_reg[0]  <= '0;
        ovf_reg[0]  <= scaled >= (XW'(den) << QW);
        side_reg[0] <= side;
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        localparam int B = QW - j;
        logic [XW-1:0] dsh;
        logic          take;

        assign dsh  = XW'(den_reg[j-1]) << B;
        assign take = rem_reg[j-1] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else
                valid_reg[j] <= valid_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]    <= take ? rem_reg[j-1] - dsh : rem_reg[j-1];
            den_reg[j]    <= den_reg[j-1];
            quo_reg[j]    <= quo_reg[j-1] | (QW'(take) << B);
            ovf_reg[j]    <= ovf_reg[j-1];
            side_reg[j]   <= side_reg[j-1];
        end
    end

    assign out_valid = valid_reg[QW];
    assign quo       = quo_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

// ===== rtl/ray_line_closest_parameter.sv =====
// ----------------------------------------------------------------------------
// ray_line_closest_parameter
// Parameter along a line of its closest point to a ray, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle (busy is always low)
// and strobes done with each result; results leave in order and the receiver
// cannot hold them off. From start to done a transaction passes 43 register
// stages, the first being the capture at the accepting edge: three dot-product
// stages, four wide-multiplier stages, two determinant stages, the divider
// entry stage, the 32-stage quotient divider and the output register. The user
// must write parallel_epsilon through cfg_we/cfg_wdata only while no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ray_line_closest_parameter #(
    parameter int PARAM_FRAC_BITS = rlcp_pkg::PARAM_FRAC_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  rlcp_pkg::ray_line_in_t       request,
    output logic                         done,
    output rlcp_pkg::ray_line_out_t      result,
    input  logic                         cfg_we,
    input  logic [rlcp_pkg::EPS_W-1:0]   cfg_wdata
);
    import rlcp_pkg::*;

    localparam int NPROD = 6;

    logic [EPS_W-1:0]         eps_reg;
    logic                     dots_valid;
    dots_t                    dots;
    logic signed [DOT_W-1:0]  mul_a [NPROD];
    logic signed [DOT_W-1:0]  mul_b [NPROD];
    logic signed [MUL_W-1:0]  mul_p [NPROD];

    // Delay line alongside the multipliers
    logic                     dly_valid_reg [MUL_LAT];
    logic                     dly_zero_reg  [MUL_LAT];
    logic signed [DOT_W-1:0]  dly_vv_reg    [MUL_LAT];
    logic signed [DOT_W-1:0]  dly_vw_reg    [MUL_LAT];

    // Determinant stage
    logic                     a_valid_reg;
    logic                     a_zero_reg;
    logic signed [NUM_W-1:0]  den_reg;
    logic signed [NUM_W-1:0]  sn_reg;
    logic signed [NUM_W-1:0]  tn_reg;
    logic signed [DOT_W-1:0]  a_vv_reg;
    logic signed [DOT_W-1:0]  a_vw_reg;

    // Magnitude and branch stage
    logic                     b_valid_reg;
    logic                     b_zero_reg;
    logic                     b_skew_reg;
    logic                     b_sray_neg_reg;
    logic                     b_s_neg_reg;
    logic                     b_t_neg_reg;
    logic                     b_f_neg_reg;
    logic [NUM_W-1:0]         den_mag_reg;
    logic [NUM_W-1:0]         sn_mag_reg;
    logic [NUM_W-1:0]         tn_mag_reg;
    logic [DOT_W-1:0]         vv_mag_reg;
    logic [DOT_W-1:0]         vw_mag_reg;
    logic [NUM_W-1:0]         den_mag_next;

    // Divider outputs
    logic                     t_valid;
    logic [PARAM_W-1:0]       s_quo;
    logic [PARAM_W-1:0]       t_quo;
    logic [PARAM_W-1:0]       f_quo;
    logic                     s_ovf;
    logic                     t_ovf;
    logic                     f_ovf;
    logic                     s_neg;
    logic                     f_neg;
    logic [3:0]               t_side;

    // Output stage
    logic                     s_ok;
    logic                     t_ok;
    logic                     f_ok;
    logic                     done_reg;
    ray_line_out_t            result_reg;
    ray_line_out_t            result_next;

    assign busy = 1'b0;

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg_we)
            eps_reg <= cfg_wdata;
    end

    // Dot products
    rlcp_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_data   (request),
        .out_valid (dots_valid),
        .out_dots  (dots)
    );

    // Wide products: uu*vv, uv*uv, uw*vv, vw*uv, uw*uv, vw*uu
    always_comb
    begin
        mul_a[0] = dots.uu;  mul_b[0] = dots.vv;
        mul_a[1] = dots.uv;  mul_b[1] = dots.uv;
        mul_a[2] = dots.uw;  mul_b[2] = dots.vv;
        mul_a[3] = dots.vw;  mul_b[3] = dots.uv;
        mul_a[4] = dots.uw;  mul_b[4] = dots.uv;
        mul_a[5] = dots.vw;  mul_b[5] = dots.uu;
    end

    for (genvar k = 0; k < NPROD; k++)
    begin : g_mul
        rlcp_wmul #(
            .W (DOT_W)
        ) u_wmul (
            .clk (clk),
            .a   (mul_a[k]),
            .b   (mul_b[k]),
            .p   (mul_p[k])
        );
    end

    // Carry the fallback terms and flags past the multipliers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MUL_LAT; i++)
                dly_valid_reg[i] <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            dly_valid_reg[0] <= dots_valid;
            for (int i = 1; i < MUL_LAT; i++)
                dly_valid_reg[i] <= dly_valid_reg[i-1];
            a_valid_reg <= dly_valid_reg[MUL_LAT-1];
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dly_zero_reg[0] <= (dots.uu == '0) || (dots.vv == '0);
        dly_vv_reg[0]   <= dots.vv;
        dly_vw_reg[0]   <= dots.vw;
        for (int i = 1; i < MUL_LAT; i++)
        begin
            dly_zero_reg[i] <= dly_zero_reg[i-1];
            dly_vv_reg[i]   <= dly_vv_reg[i-1];
            dly_vw_reg[i]   <= dly_vw_reg[i-1];
        end
    end

    // Determinant and skew numerators
    always_ff @(posedge clk)
    begin
        den_reg    <= NUM_W'(mul_p[0]) - NUM_W'(mul_p[1]);
        sn_reg     <= NUM_W'(mul_p[2]) - NUM_W'(mul_p[3]);
        tn_reg     <= NUM_W'(mul_p[4]) - NUM_W'(mul_p[5]);
        a_zero_reg <= dly_zero_reg[MUL_LAT-1];
        a_vv_reg   <= dly_vv_reg[MUL_LAT-1];
        a_vw_reg   <= dly_vw_reg[MUL_LAT-1];
    end

    // Magnitudes, signs and the parallel test
    assign den_mag_next = den_reg[NUM_W-1] ? $unsigned(-den_reg) : $unsigned(den_reg);

    always_ff @(posedge clk)
    begin
        den_mag_reg    <= den_mag_next;
        sn_mag_reg     <= sn_reg[NUM_W-1] ? $unsigned(-sn_reg) : $unsigned(sn_reg);
        tn_mag_reg     <= tn_reg[NUM_W-1] ? $unsigned(-tn_reg) : $unsigned(tn_reg);
        vv_mag_reg     <= $unsigned(a_vv_reg);
        vw_mag_reg     <= a_vw_reg[DOT_W-1] ? $unsigned(-a_vw_reg) : $unsigned(a_vw_reg);
        b_zero_reg     <= a_zero_reg;
        b_skew_reg     <= den_mag_next > NUM_W'(eps_reg);
        b_sray_neg_reg <= (sn_reg != '0) && (sn_reg[NUM_W-1] != den_reg[NUM_W-1]);
        b_s_neg_reg    <= sn_reg[NUM_W-1] ^ den_reg[NUM_W-1];
        b_t_neg_reg    <= tn_reg[NUM_W-1] ^ den_reg[NUM_W-1];
        b_f_neg_reg    <= (a_vw_reg != '0) && !a_vw_reg[DOT_W-1];
    end

    // Quotient pipelines: skew s, skew t, and the -vw/vv fallback
    rlcp_div #(
        .NW (NUM_W), .DW (NUM_W), .QW (PARAM_W), .FRAC (PARAM_FRAC_BITS), .SW (1)
    ) u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .num       (sn_mag_reg),
        .den       (den_mag_reg),
        .side      (b_s_neg_reg),
        .out_valid (),
        .quo       (s_quo),
        .ovf       (s_ovf),
        .side_out  (s_neg)
    );

    rlcp_div #(
        .NW (NUM_W), .DW (NUM_W), .QW (PARAM_W), .FRAC (PARAM_FRAC_BITS), .SW (4)
    ) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .num       (tn_mag_reg),
        .den       (den_mag_reg),
        .side      ({b_zero_reg, b_skew_reg, b_sray_neg_reg, b_t_neg_reg}),
        .out_valid (t_valid),
        .quo       (t_quo),
        .ovf       (t_ovf),
        .side_out  (t_side)
    );

    rlcp_div #(
        .NW (DOT_W), .DW (DOT_W), .QW (PARAM_W), .FRAC (PARAM_FRAC_BITS), .SW (1)
    ) u_div_f (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .num       (vw_mag_reg),
        .den       (vv_mag_reg),
        .side      (b_f_neg_reg),
        .out_valid (),
        .quo       (f_quo),
        .ovf       (f_ovf),
        .side_out  (f_neg)
    );

    // Range checks: a negative result may reach one past the positive limit
    function automatic logic quo_fits(input logic [PARAM_W-1:0] q, input logic ovf_in,
                                      input logic neg);
        logic [PARAM_W-1:0] lim;
        lim = neg ? {1'b1, {(PARAM_W-1){1'b0}}} : {1'b0, {(PARAM_W-1){1'b1}}};
        return !ovf_in && (q <= lim);
    endfunction

    function automatic logic [PARAM_W-1:0] apply_sign(input logic [PARAM_W-1:0] q,
                                                      input logic neg);
        return neg ? (~q + 1'b1) : q;
    endfunction

    assign s_ok = quo_fits(s_quo, s_ovf, s_neg);
    assign t_ok = quo_fits(t_quo, t_ovf, t_side[0]);
    assign f_ok = quo_fits(f_quo, f_ovf, f_neg);

    // Pick the branch; drop to zero on any failure
    always_comb
    begin
        result_next.line_param  = '0;
        result_next.param_valid = 1'b0;
        priority if (t_side[3])
        begin
            result_next.param_valid = 1'b0;
        end
        else if (t_side[2] && !(s_ok && t_ok))
        begin
            result_next.param_valid = 1'b0;
        end
        else if (t_side[2] && !t_side[1])
        begin
            result_next.line_param  = $signed(apply_sign(t_quo, t_side[0]));
            result_next.param_valid = 1'b1;
        end
        else if (f_ok)
        begin
            result_next.line_param  = $signed(apply_sign(f_quo, f_neg));
            result_next.param_valid = 1'b1;
        end
        else
        begin
            result_next.param_valid = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= t_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
